### design/utra_pkg.sv
package utra_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int REM_W       = RADIX_W + 1;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int DEPTH_W     = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [RADIX_W-1:0] DIGIT_LIMIT  = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = CHAR_W'(97);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = CHAR_LOWER_A - CHAR_W'(DIGIT_LIMIT);

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture value, clear digit stack
    logic step;   // one restoring division step
    logic push;   // store remainder as next digit
    logic pop;    // read top digit
    logic show;   // load output character register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_last;
    logic quo_zero;
    logic depth_zero;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_LIMIT) begin
      return dx + CHAR_ZERO;
    end
    return dx + CHAR_ALPHA_BASE;
  endfunction

endpackage

### design/unsigned_to_radix_ascii_unit.sv
// Converts an unsigned 32-bit value to ASCII digits in the base held in the
// radix register (2..36, writes outside that range saturate; reset value 10).
// Digits leave most significant first as '0'-'9' then 'a'-'z', one beat per
// character, with last set on the final one; zero gives a single '0'.
// One value is converted at a time: in_ready is high only while idle. Each
// digit is produced by the bit-serial restoring divider, which shifts the
// whole quotient through and then pushes the remainder on the digit stack;
// each character is then read back from the stack, loaded into the output
// register and presented until taken. The radix may be written only while
// the unit is idle.
module unsigned_to_radix_ascii_unit
  import utra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last
);

  cmd_t    cmd;
  status_t status;

  utra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  utra_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule

### design/utra_ctrl.sv
module utra_ctrl
  import utra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PUSH,
    S_READ,
    S_LOAD,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.step = (state == S_DIV);
    cmd.push = (state == S_PUSH);
    cmd.pop  = (state == S_READ);
    cmd.show = (state == S_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_DIV;
            in_ready <= 1'b0;
          end
        end
        S_DIV: begin
          if (status.step_last) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          state <= status.quo_zero ? S_READ : S_DIV;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (status.depth_zero) begin
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

### design/utra_datapath.sv
module utra_datapath
  import utra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [RADIX_W-1:0]     cfg_data,
  input  logic [VALUE_WIDTH-1:0] value,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last
);

  logic [RADIX_W-1:0]     radix;
  logic [VALUE_WIDTH-1:0] quo;
  logic [REM_W-1:0]       rem;
  logic [STEP_W-1:0]      step;
  logic [DEPTH_W-1:0]     depth;
  logic [DEPTH_W-1:0]     depth_m1;
  logic [RADIX_W-1:0]     rd_digit;
  logic [RADIX_W-1:0]     stack [VALUE_WIDTH];

  logic [REM_W-1:0]       rem_shift;
  logic                   ge;
  logic [REM_W-1:0]       rem_next;

  // restoring division, one quotient bit per cycle
  assign rem_shift = {rem[REM_W-2:0], quo[VALUE_WIDTH-1]};
  assign ge        = rem_shift >= REM_W'(radix);
  assign rem_next  = ge ? (rem_shift - REM_W'(radix)) : rem_shift;
  assign depth_m1  = depth - DEPTH_W'(1);

  assign status.step_last  = (step == STEP_W'(VALUE_WIDTH - 1));
  assign status.quo_zero   = (quo == '0);
  assign status.depth_zero = (depth == '0);

  // register holds the clamped base
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write) begin
      if (cfg_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      depth <= '0;
    end else begin
      if (cmd.load) begin
        step  <= '0;
        depth <= '0;
      end else if (cmd.step) begin
        step <= step + STEP_W'(1);
      end else if (cmd.push) begin
        step  <= '0;
        depth <= depth + DEPTH_W'(1);
      end else if (cmd.pop) begin
        depth <= depth_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= value;
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[VALUE_WIDTH-2:0], ge};
      rem <= rem_next;
    end else if (cmd.push) begin
      rem <= '0;
    end
  end

  // digit stack: digits arrive least significant first, leave most significant first
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[depth[IDX_W-1:0]] <= rem[RADIX_W-1:0];
    end
    if (cmd.pop) begin
      rd_digit <= stack[depth_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show) begin
      digit_char <= digit_to_char(rd_digit);
      last       <= (depth == '0);
    end
  end

endmodule

### design/utra_checker.sv
module utra_checker
  import utra_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [CHAR_W-1:0]      digit_char,
  input logic                   last
);

  // a stalled output beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
    else $error("output beat changed while stalled");

  // one value in flight: never ready for input while a character is shown
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= CHAR_ZERO && digit_char <= CHAR_ZERO + CHAR_W'(9)) ||
                  (digit_char >= CHAR_LOWER_A && digit_char <= CHAR_LOWER_A + CHAR_W'(25)))
    else $error("character outside digit set");

  // the final character of a value returns the unit to idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("not idle after last character");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("idle before last character");

endmodule

bind unsigned_to_radix_ascii_unit utra_checker u_utra_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit_char (digit_char),
  .last       (last)
);
